// ===== rtl/core/luhn_card_brand_check_defines.svh =====
// assertion macros for the luhn card brand check
`ifndef LUHN_CARD_BRAND_CHECK_DEFINES_SVH
`define LUHN_CARD_BRAND_CHECK_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LCBC_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("luhn_card_brand_check: same-cycle check failed");

// next-cycle implication, checked outside reset
`define LCBC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("luhn_card_brand_check: next-cycle check failed");

`endif

// ===== rtl/core/lcbc_pkg.sv =====
// types, constants and codes shared by the luhn card brand check
`timescale 1ns / 1ps
package lcbc_pkg;

  localparam int CARD_W             = 54;
  localparam int DIGIT_W            = 4;
  localparam int BCD_DIGITS         = 17;
  localparam int CNT_W              = $clog2(CARD_W);
  localparam int IDX_W              = $clog2(BCD_DIGITS);
  localparam int COUNT_W            = $clog2(BCD_DIGITS + 1);
  localparam int MAX_DIGITS_DEFAULT = 16;

  localparam logic [1:0] VERDICT_INVALID = 2'd0;
  localparam logic [1:0] VERDICT_AMEX    = 2'd1;
  localparam logic [1:0] VERDICT_MASTER  = 2'd2;
  localparam logic [1:0] VERDICT_VISA    = 2'd3;

  localparam logic [DIGIT_W-1:0] MC_HI      = 4'd5;
  localparam logic [DIGIT_W-1:0] MC_LO_MIN  = 4'd1;
  localparam logic [DIGIT_W-1:0] MC_LO_MAX  = 4'd5;
  localparam logic [DIGIT_W-1:0] AMEX_HI    = 4'd3;
  localparam logic [DIGIT_W-1:0] AMEX_LO_A  = 4'd4;
  localparam logic [DIGIT_W-1:0] AMEX_LO_B  = 4'd7;
  localparam logic [DIGIT_W-1:0] VISA_HI    = 4'd4;
  localparam logic [DIGIT_W-1:0] NINE       = 4'd9;

  localparam logic [COUNT_W-1:0] MC_LEN     = COUNT_W'(16);
  localparam logic [COUNT_W-1:0] AMEX_LEN   = COUNT_W'(15);
  localparam logic [COUNT_W-1:0] VISA_LEN_A = COUNT_W'(13);
  localparam logic [COUNT_W-1:0] VISA_LEN_B = COUNT_W'(16);

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_DABBLE,
    OP_DIGIT
  } bcd_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic             clear;
    logic             step;
    logic [IDX_W-1:0] idx;
  } scan_ctrl_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       out_of_range;
  } scan_res_t;

endpackage

// ===== rtl/core/lcbc_bcd.sv =====
// bit-serial binary to bcd converter with a digit-serial readout
`timescale 1ns / 1ps
module lcbc_bcd (
  input  logic                           clk_i,
  input  lcbc_pkg::bcd_op_e              op_i,
  input  logic [lcbc_pkg::CARD_W-1:0]    number_i,
  output logic [lcbc_pkg::DIGIT_W-1:0]   digit_o
);
  import lcbc_pkg::*;

  logic [CARD_W-1:0]  bin_q;
  logic [DIGIT_W-1:0] bcd_q   [BCD_DIGITS];
  logic [DIGIT_W-1:0] adj     [BCD_DIGITS];
  logic [DIGIT_W-1:0] dabble  [BCD_DIGITS];
  logic [DIGIT_W-1:0] dshift  [BCD_DIGITS];

  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      adj[k] = (bcd_q[k] >= DIGIT_W'(5)) ? bcd_q[k] + DIGIT_W'(3) : bcd_q[k];
    end
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (k == 0) begin
        dabble[k] = {adj[k][DIGIT_W-2:0], bin_q[CARD_W-1]};
      end else begin
        dabble[k] = {adj[k][DIGIT_W-2:0], adj[k-1][DIGIT_W-1]};
      end
      if (k == BCD_DIGITS - 1) begin
        dshift[k] = '0;
      end else begin
        dshift[k] = bcd_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        bin_q <= number_i;
        for (int k = 0; k < BCD_DIGITS; k++) bcd_q[k] <= '0;
      end
      OP_DABBLE: begin
        bin_q <= {bin_q[CARD_W-2:0], 1'b0};
        bcd_q <= dabble;
      end
      OP_DIGIT: begin
        bcd_q <= dshift;
      end
      default: begin
      end
    endcase
  end

  assign digit_o = bcd_q[0];

endmodule

// ===== rtl/core/lcbc_scan.sv =====
// digit-serial luhn sum, digit count, leading digits and brand decision
`timescale 1ns / 1ps
module lcbc_scan #(
  parameter int MAX_DIGITS = lcbc_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcbc_pkg::scan_ctrl_t          ctrl_i,
  input  logic [lcbc_pkg::DIGIT_W-1:0]  digit_i,
  output lcbc_pkg::scan_res_t           res_o
);
  import lcbc_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_DIGITS);

  logic [DIGIT_W-1:0] sum_q, sum_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [DIGIT_W-1:0] hi_q, hi_d;
  logic [DIGIT_W-1:0] lo_q, lo_d;
  logic [DIGIT_W-1:0] prev_q, prev_d;
  logic               all9_q, all9_d;

  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W:0]   contrib;
  logic [DIGIT_W:0]   acc;
  logic               luhn_ok;
  logic               two_plus;

  always_comb begin
    dbl     = {digit_i, 1'b0};
    if (ctrl_i.idx[0]) begin
      contrib = (dbl < (DIGIT_W+1)'(10)) ? dbl : dbl - (DIGIT_W+1)'(9);
    end else begin
      contrib = {1'b0, digit_i};
    end
    acc     = {1'b0, sum_q} + contrib;

    sum_d   = sum_q;
    count_d = count_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    prev_d  = prev_q;
    all9_d  = all9_q;
    if (ctrl_i.clear) begin
      sum_d   = '0;
      count_d = '0;
      hi_d    = '0;
      lo_d    = '0;
      prev_d  = '0;
      all9_d  = 1'b1;
    end else if (ctrl_i.step) begin
      sum_d  = (acc >= (DIGIT_W+1)'(10)) ? DIGIT_W'(acc - (DIGIT_W+1)'(10))
                                          : acc[DIGIT_W-1:0];
      prev_d = digit_i;
      if (digit_i != '0) begin
        count_d = COUNT_W'(ctrl_i.idx) + COUNT_W'(1);
        hi_d    = digit_i;
        lo_d    = prev_q;
      end
      if (COUNT_W'(ctrl_i.idx) < MaxCount) begin
        all9_d = all9_q & (digit_i == NINE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      all9_q  <= 1'b1;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      all9_q  <= all9_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    prev_q <= prev_d;
  end

  always_comb begin
    luhn_ok  = (sum_q == '0);
    two_plus = (count_q >= COUNT_W'(2));
    res_o.out_of_range = (count_q == '0) || (count_q > MaxCount) ||
                         ((count_q == MaxCount) && all9_q);
    res_o.verdict = VERDICT_INVALID;
    if (res_o.out_of_range || !luhn_ok) begin
      res_o.verdict = VERDICT_INVALID;
    end else if (two_plus && (hi_q == MC_HI) && (lo_q inside {[MC_LO_MIN:MC_LO_MAX]}) &&
                 (count_q == MC_LEN)) begin
      res_o.verdict = VERDICT_MASTER;
    end else if (two_plus && (hi_q == AMEX_HI) && (lo_q inside {AMEX_LO_A, AMEX_LO_B}) &&
                 (count_q == AMEX_LEN)) begin
      res_o.verdict = VERDICT_AMEX;
    end else if ((hi_q == VISA_HI) && (count_q inside {VISA_LEN_A, VISA_LEN_B})) begin
      res_o.verdict = VERDICT_VISA;
    end
  end

endmodule

// ===== rtl/core/luhn_card_brand_check.sv =====
// Luhn check and brand classification of one card number per transaction. The
// number is converted to 17 bcd digits one bit per cycle, then the digits are
// read out least significant first, one per cycle, into the Luhn sum, digit
// count and leading digit registers; from there the verdict moves into the
// output register once that register is free or its result is being taken.
// in_stall_o is high from acceptance until the result has moved to the output
// register, which then holds it until taken.
`timescale 1ns / 1ps
`include "luhn_card_brand_check_defines.svh"
module luhn_card_brand_check #(
  parameter int MAX_DIGITS = lcbc_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lcbc_pkg::CARD_W-1:0] card_number_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  verdict_o,
  output logic                        out_of_range_o
);
  import lcbc_pkg::*;

  localparam logic [CNT_W-1:0] ConvLast = CNT_W'(CARD_W - 1);
  localparam logic [CNT_W-1:0] ScanLast = CNT_W'(BCD_DIGITS - 1);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         verdict_q;
  logic               oor_q;

  bcd_op_e            bcd_op;
  scan_ctrl_t         scan_ctrl;
  scan_res_t          scan_res;
  logic [DIGIT_W-1:0] digit;
  logic               out_load;

  lcbc_bcd u_bcd (
    .clk_i    (clk_i),
    .op_i     (bcd_op),
    .number_i (card_number_i),
    .digit_o  (digit)
  );

  lcbc_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scan_ctrl),
    .digit_i (digit),
    .res_o   (scan_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CONV;
      ST_CONV: if (cnt_q == ConvLast) state_d = ST_SCAN;
      ST_SCAN: if (cnt_q == ScanLast) state_d = ST_FIN;
      ST_FIN:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o      = 1'b1;
    bcd_op          = OP_HOLD;
    scan_ctrl.clear = 1'b0;
    scan_ctrl.step  = 1'b0;
    scan_ctrl.idx   = cnt_q[IDX_W-1:0];
    out_load        = 1'b0;
    cnt_d           = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          bcd_op          = OP_LOAD;
          scan_ctrl.clear = 1'b1;
          cnt_d           = '0;
        end
      end
      ST_CONV: begin
        bcd_op = OP_DABBLE;
        cnt_d  = (cnt_q == ConvLast) ? '0 : cnt_q + CNT_W'(1);
      end
      ST_SCAN: begin
        bcd_op         = OP_DIGIT;
        scan_ctrl.step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
      end
      ST_FIN: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q <= scan_res.verdict;
      oor_q     <= scan_res.out_of_range;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = verdict_q;
  assign out_of_range_o = oor_q;

  `LCBC_ASSERT_NEXT(a_accept_starts_conv, in_valid_i && !in_stall_o, state_q == ST_CONV)
  `LCBC_ASSERT_NEXT(a_scan_ends_in_fin, (state_q == ST_SCAN) && (cnt_q == ScanLast),
                    state_q == ST_FIN)
  `LCBC_ASSERT_NOW(a_oor_is_invalid, out_valid_o && out_of_range_o,
                   verdict_o == VERDICT_INVALID)

endmodule
